// ===== rtl/id3d_pkg.sv =====
// Shared types, codes and frame-ID classification for the ID3v2 tag deframer.
`timescale 1ns / 1ps

package id3d_pkg;

  localparam int unsigned SIZE_W  = 28;
  localparam int unsigned IDENT_W = 32;

  // Byte roles
  localparam logic [2:0] ROLE_TAGHDR   = 3'd0;
  localparam logic [2:0] ROLE_EXTHDR   = 3'd1;
  localparam logic [2:0] ROLE_FRAMEHDR = 3'd2;
  localparam logic [2:0] ROLE_PAYLOAD  = 3'd3;
  localparam logic [2:0] ROLE_PADDING  = 3'd4;
  localparam logic [2:0] ROLE_PAST     = 3'd5;

  // Frame kinds
  localparam logic [4:0] KIND_UNKNOWN = 5'd0;
  localparam logic [4:0] KIND_TEXT    = 5'd1;
  localparam logic [4:0] KIND_TXXX    = 5'd2;
  localparam logic [4:0] KIND_URL     = 5'd3;
  localparam logic [4:0] KIND_WXXX    = 5'd4;
  localparam logic [4:0] KIND_NAMED0  = 5'd5;
  localparam logic [4:0] KIND_PRIV    = 5'd23;
  localparam logic [4:0] KIND_ZERO    = 5'd24;

  localparam logic [7:0]  CHAR_T   = 8'h54;
  localparam logic [7:0]  CHAR_W   = 8'h57;
  localparam logic [23:0] TAIL_XXX = 24'h58_5858;
  localparam logic [IDENT_W-1:0] ID_PRIV = "PRIV";

  localparam int unsigned NUM_NAMED = 18;
  localparam logic [IDENT_W-1:0] NAMED_IDS [NUM_NAMED] = '{
    "UFID", "ETCO", "USLT", "SYLT", "COMM", "RVA2", "EQU2", "PCNT", "POPM",
    "RBUF", "LINK", "POSS", "USER", "OWNE", "COMR", "SEEK", "ENCR", "GRID"
  };

  // Queue between parser and result stage
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One parsed word handed from the parser to the result stage
  typedef struct packed {
    logic [7:0]         data;
    logic [2:0]         role;
    logic               hdone;
    logic               flast;
    logic               tend;
    logic               hdr_zero;
    logic [IDENT_W-1:0] ident;
    logic [SIZE_W-1:0]  size;
    logic [SIZE_W-1:0]  payload_left;
    logic [SIZE_W-1:0]  tag_size;
    logic [3:0]         flags;
    logic [7:0]         version;
  } id3d_entry_t;

  function automatic logic [4:0] classify(input logic [IDENT_W-1:0] id);
    logic [4:0] k;
    k = KIND_UNKNOWN;
    if (id[31:24] == CHAR_T) begin
      k = (id[23:0] == TAIL_XXX) ? KIND_TXXX : KIND_TEXT;
    end else if (id[31:24] == CHAR_W) begin
      k = (id[23:0] == TAIL_XXX) ? KIND_WXXX : KIND_URL;
    end else if (id == ID_PRIV) begin
      k = KIND_PRIV;
    end else begin
      for (int i = 0; i < NUM_NAMED; i++) begin
        if (id == NAMED_IDS[i]) k = KIND_NAMED0 + 5'(i);
      end
    end
    return k;
  endfunction

endpackage

// ===== rtl/id3v2_tag_deframer_top.sv =====
// Words go from the queue to the output register when it is empty or being popped.
// Throughput: one byte per cycle unless full; parser state updates once per byte.
// A two-entry queue separates the parser from the output register, so a stalled
//   consumer does not stop input until both hold words.
// Reset: asynchronous, active low; parser returns to the tag header, queue and
//   output register are emptied.
`timescale 1ns / 1ps

module id3v2_tag_deframer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    data_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    data_out_o,
  output logic [2:0]                    byte_role_o,
  output logic [4:0]                    frame_kind_o,
  output logic [id3d_pkg::SIZE_W-1:0]   payload_offset_o,
  output logic [id3d_pkg::SIZE_W-1:0]   frame_size_o,
  output logic [id3d_pkg::SIZE_W-1:0]   tag_size_o,
  output logic [3:0]                    tag_flags_o,
  output logic [7:0]                    tag_version_o,
  output logic                          header_done_o,
  output logic                          frame_last_o,
  output logic                          tag_end_o
);

  id3d_pkg::id3d_entry_t front_entry;
  id3d_pkg::id3d_entry_t head_entry;
  logic                  accept;
  logic                  head_valid;
  logic                  head_take;

  assign accept = push && !full;

  id3d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .entry_o     (front_entry)
  );

  id3d_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_data_i (front_entry),
    .full_o    (full),
    .rd_en_i   (head_take),
    .valid_o   (head_valid),
    .rd_data_o (head_entry)
  );

  id3d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (head_valid),
    .in_entry_i       (head_entry),
    .in_take_o        (head_take),
    .empty            (empty),
    .pop              (pop),
    .data_out_o       (data_out_o),
    .byte_role_o      (byte_role_o),
    .frame_kind_o     (frame_kind_o),
    .payload_offset_o (payload_offset_o),
    .frame_size_o     (frame_size_o),
    .tag_size_o       (tag_size_o),
    .tag_flags_o      (tag_flags_o),
    .tag_version_o    (tag_version_o),
    .header_done_o    (header_done_o),
    .frame_last_o     (frame_last_o),
    .tag_end_o        (tag_end_o)
  );

endmodule

// ===== rtl/id3d_front.sv =====
// Parser front end: tracks tag, extended-header, frame-header and payload phases.
`timescale 1ns / 1ps

module id3d_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  output id3d_pkg::id3d_entry_t entry_o
);

  localparam logic [2:0] PH_TAGHDR   = 3'd0;
  localparam logic [2:0] PH_EXTHDR   = 3'd1;
  localparam logic [2:0] PH_FRAMEHDR = 3'd2;
  localparam logic [2:0] PH_PAYLOAD  = 3'd3;
  localparam logic [2:0] PH_PAST     = 3'd5;

  logic [2:0]                     phase_q, phase_d;
  logic [3:0]                     cnt_q, cnt_d;
  logic [id3d_pkg::IDENT_W-1:0]   ident_q, ident_d;
  logic [id3d_pkg::SIZE_W-1:0]    size_q, size_d;
  logic                           allzero_q, allzero_d;
  logic [id3d_pkg::SIZE_W-1:0]    pl_q, pl_d;
  logic [id3d_pkg::SIZE_W-1:0]    body_q, body_d;
  logic [id3d_pkg::SIZE_W-1:0]    tag_size_q, tag_size_d;
  logic [3:0]                     flags_q, flags_d;
  logic [7:0]                     ver_q, ver_d;
  logic                           in_body;
  logic                           hz;
  logic [id3d_pkg::SIZE_W-1:0]    pl_dec;
  logic [id3d_pkg::SIZE_W-1:0]    body_dec;
  id3d_pkg::id3d_entry_t          ent;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    ident_d    = ident_q;
    size_d     = size_q;
    allzero_d  = allzero_q;
    pl_d       = pl_q;
    body_d     = body_q;
    tag_size_d = tag_size_q;
    flags_d    = flags_q;
    ver_d      = ver_q;
    in_body    = 1'b0;
    hz         = allzero_q && (data_byte_i == 8'd0);
    pl_dec     = (pl_q != '0) ? pl_q - 1'b1 : pl_q;
    body_dec   = (body_q != '0) ? body_q - 1'b1 : body_q;
    ent        = '0;
    ent.data   = data_byte_i;
    ent.role   = id3d_pkg::ROLE_PAST;

    case (phase_q)
      PH_TAGHDR: begin
        ent.role = id3d_pkg::ROLE_TAGHDR;
        if (cnt_q == 4'd3) ver_d = data_byte_i;
        if (cnt_q == 4'd5) flags_d = data_byte_i[7:4];
        if (cnt_q == 4'd6) begin
          size_d = {21'd0, data_byte_i[6:0]};
        end else if (cnt_q > 4'd6) begin
          size_d = {size_q[20:0], data_byte_i[6:0]};
        end
        if (cnt_q >= 4'd9) begin
          tag_size_d = size_d;
          body_d     = size_d;
          cnt_d      = '0;
          allzero_d  = 1'b1;
          if (size_d == '0) begin
            ent.tend = 1'b1;
            phase_d  = PH_PAST;
          end else begin
            phase_d = flags_d[2] ? PH_EXTHDR : PH_FRAMEHDR;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PH_EXTHDR: begin
        ent.role = id3d_pkg::ROLE_EXTHDR;
        in_body  = 1'b1;
        if (cnt_q >= 4'd5) begin
          cnt_d   = '0;
          phase_d = PH_FRAMEHDR;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PH_FRAMEHDR: begin
        in_body   = 1'b1;
        ent.role  = hz ? id3d_pkg::ROLE_PADDING : id3d_pkg::ROLE_FRAMEHDR;
        allzero_d = hz;
        if (cnt_q < 4'd4) ident_d = {ident_q[23:0], data_byte_i};
        if (cnt_q == 4'd4) begin
          size_d = {21'd0, data_byte_i[6:0]};
        end else if (cnt_q > 4'd4 && cnt_q < 4'd8) begin
          size_d = {size_q[20:0], data_byte_i[6:0]};
        end
        if (cnt_q >= 4'd9) begin
          // hand the raw ID and size to the result stage for classification
          ent.hdone    = 1'b1;
          ent.hdr_zero = hz;
          ent.ident    = ident_d;
          ent.size     = size_d;
          cnt_d        = '0;
          allzero_d    = 1'b1;
          if (!hz && size_q != '0) begin
            pl_d    = size_q;
            phase_d = PH_PAYLOAD;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PH_PAYLOAD: begin
        ent.role         = id3d_pkg::ROLE_PAYLOAD;
        in_body          = 1'b1;
        ent.payload_left = pl_q;
        pl_d             = pl_dec;
        if (pl_dec == '0) begin
          ent.flast = 1'b1;
          phase_d   = PH_FRAMEHDR;
        end
      end
      default: begin
        ent.role = id3d_pkg::ROLE_PAST;
      end
    endcase

    // every body byte counts against the tag size; cut off when it runs out
    if (in_body) begin
      body_d = body_dec;
      if (body_dec == '0) begin
        ent.tend = 1'b1;
        phase_d  = PH_PAST;
      end
    end

    ent.tag_size = tag_size_d;
    ent.flags    = flags_d;
    ent.version  = ver_d;
  end

  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TAGHDR;
      cnt_q      <= '0;
      ident_q    <= '0;
      size_q     <= '0;
      allzero_q  <= 1'b1;
      pl_q       <= '0;
      body_q     <= '0;
      tag_size_q <= '0;
      flags_q    <= '0;
      ver_q      <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      ident_q    <= ident_d;
      size_q     <= size_d;
      allzero_q  <= allzero_d;
      pl_q       <= pl_d;
      body_q     <= body_d;
      tag_size_q <= tag_size_d;
      flags_q    <= flags_d;
      ver_q      <= ver_d;
    end
  end

endmodule

// ===== rtl/id3d_queue.sv =====
// Short register queue between the parser and the result stage.
`timescale 1ns / 1ps

module id3d_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  id3d_pkg::id3d_entry_t wr_data_i,
  output logic                  full_o,
  input  logic                  rd_en_i,
  output logic                  valid_o,
  output id3d_pkg::id3d_entry_t rd_data_o
);

  id3d_pkg::id3d_entry_t                  mem_q [id3d_pkg::QUEUE_DEPTH];
  logic [id3d_pkg::QUEUE_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [id3d_pkg::QUEUE_CNT_W-1:0]       cnt_q;
  logic                                   do_wr, do_rd;

  assign full_o    = (cnt_q == id3d_pkg::QUEUE_CNT_W'(id3d_pkg::QUEUE_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  function automatic logic [id3d_pkg::QUEUE_PTR_W-1:0] ptr_inc(
    input logic [id3d_pkg::QUEUE_PTR_W-1:0] p
  );
    return (p == id3d_pkg::QUEUE_PTR_W'(id3d_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_rd) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/id3d_back.sv =====
// Result stage: classifies frame IDs, holds frame kind and size, forms payload offsets.
`timescale 1ns / 1ps

module id3d_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  id3d_pkg::id3d_entry_t         in_entry_i,
  output logic                          in_take_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    data_out_o,
  output logic [2:0]                    byte_role_o,
  output logic [4:0]                    frame_kind_o,
  output logic [id3d_pkg::SIZE_W-1:0]   payload_offset_o,
  output logic [id3d_pkg::SIZE_W-1:0]   frame_size_o,
  output logic [id3d_pkg::SIZE_W-1:0]   tag_size_o,
  output logic [3:0]                    tag_flags_o,
  output logic [7:0]                    tag_version_o,
  output logic                          header_done_o,
  output logic                          frame_last_o,
  output logic                          tag_end_o
);

  logic                          out_valid_q;
  logic [4:0]                    held_kind_q, held_kind_d;
  logic [id3d_pkg::SIZE_W-1:0]   held_fs_q, held_fs_d;
  logic [4:0]                    kind_new, kind_d;
  logic [id3d_pkg::SIZE_W-1:0]   fs_new, fs_d, off_d;
  logic                          take;

  // refill the output register when it is empty or being drained this cycle
  assign take      = in_valid_i && (!out_valid_q || pop);
  assign in_take_o = take;
  assign empty     = !out_valid_q;

  always_comb begin
    kind_new    = in_entry_i.hdr_zero ? id3d_pkg::KIND_ZERO
                                      : id3d_pkg::classify(in_entry_i.ident);
    fs_new      = in_entry_i.hdr_zero ? '0 : in_entry_i.size;
    held_kind_d = held_kind_q;
    held_fs_d   = held_fs_q;
    kind_d      = id3d_pkg::KIND_UNKNOWN;
    fs_d        = '0;
    off_d       = '0;
    if (in_entry_i.hdone) begin
      held_kind_d = kind_new;
      held_fs_d   = fs_new;
      kind_d      = kind_new;
      fs_d        = fs_new;
    end else if (in_entry_i.role == id3d_pkg::ROLE_PAYLOAD) begin
      kind_d = held_kind_q;
      fs_d   = held_fs_q;
      off_d  = held_fs_q - in_entry_i.payload_left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_kind_q <= '0;
      held_fs_q   <= '0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        held_kind_q <= held_kind_d;
        held_fs_q   <= held_fs_d;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_out_o       <= in_entry_i.data;
      byte_role_o      <= in_entry_i.role;
      frame_kind_o     <= kind_d;
      payload_offset_o <= off_d;
      frame_size_o     <= fs_d;
      tag_size_o       <= in_entry_i.tag_size;
      tag_flags_o      <= in_entry_i.flags;
      tag_version_o    <= in_entry_i.version;
      header_done_o    <= in_entry_i.hdone;
      frame_last_o     <= in_entry_i.flast;
      tag_end_o        <= in_entry_i.tend;
    end
  end

endmodule

// ===== rtl/id3d_checker.sv =====
// Port-level checks for the ID3v2 tag deframer, bound to the top level.
`timescale 1ns / 1ps

module id3d_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push,
  input logic                          full,
  input logic [7:0]                    data_byte_i,
  input logic                          empty,
  input logic                          pop,
  input logic [7:0]                    data_out_o,
  input logic [2:0]                    byte_role_o,
  input logic [4:0]                    frame_kind_o,
  input logic [id3d_pkg::SIZE_W-1:0]   payload_offset_o,
  input logic [id3d_pkg::SIZE_W-1:0]   frame_size_o,
  input logic [id3d_pkg::SIZE_W-1:0]   tag_size_o,
  input logic [3:0]                    tag_flags_o,
  input logic [7:0]                    tag_version_o,
  input logic                          header_done_o,
  input logic                          frame_last_o,
  input logic                          tag_end_o
);

  // a completed frame header is either a real header or a padding block
  a_hdone_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && header_done_o) |->
      (byte_role_o == id3d_pkg::ROLE_FRAMEHDR || byte_role_o == id3d_pkg::ROLE_PADDING))
    else $error("header_done on a byte that is not a frame header");

  // last payload byte sits at the end of the decoded frame size
  a_flast_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_last_o) |->
      (byte_role_o == id3d_pkg::ROLE_PAYLOAD && payload_offset_o + 1'b1 == frame_size_o))
    else $error("frame_last does not match offset and frame size");

  // past the tag all frame fields read zero
  a_past_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && byte_role_o == id3d_pkg::ROLE_PAST) |->
      (frame_kind_o == id3d_pkg::KIND_UNKNOWN && payload_offset_o == '0 &&
       frame_size_o == '0 && !header_done_o && !frame_last_o))
    else $error("frame fields not cleared past the tag");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(data_out_o) && $stable(byte_role_o)))
    else $error("result word changed while stalled");

endmodule

bind id3v2_tag_deframer_top id3d_checker u_id3d_checker (.*);

// ===== test/id3v2_deframer_checker.sv =====
// Checker for the ID3v2 tag deframer: tracks the tag parse, predicts each word and compares.
`timescale 1ns / 1ps

module id3v2_deframer_checker
  import id3d_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [7:0]        data_byte_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  logic [7:0]        data_out_i,
  input  logic [2:0]        byte_role_i,
  input  logic [4:0]        frame_kind_i,
  input  logic [SIZE_W-1:0] payload_offset_i,
  input  logic [SIZE_W-1:0] frame_size_i,
  input  logic [SIZE_W-1:0] tag_size_i,
  input  logic [3:0]        tag_flags_i,
  input  logic [7:0]        tag_version_i,
  input  logic              header_done_i,
  input  logic              frame_last_i,
  input  logic              tag_end_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       headers_o,
  output logic [24:0]       kinds_o
);

  typedef enum logic [2:0] {P_TAGHDR, P_EXTHDR, P_FRAMEHDR, P_PAYLOAD, P_PAST} parse_phase_e;

  typedef struct packed {
    logic [7:0]        data;
    logic [2:0]        role;
    logic [4:0]        kind;
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] fsize;
    logic [SIZE_W-1:0] tsize;
    logic [3:0]        flags;
    logic [7:0]        version;
    logic              hdone;
    logic              flast;
    logic              tend;
  } byte_word_t;

  parse_phase_e      phase_q;
  logic [3:0]        hdr_cnt;
  logic [31:0]       ident;
  logic [SIZE_W-1:0] size_acc;
  logic              all_zero;
  logic [SIZE_W-1:0] left;
  logic [SIZE_W-1:0] body_left;
  logic [SIZE_W-1:0] tag_size_q;
  logic [3:0]        flags_q;
  logic [7:0]        version_q;
  logic [4:0]        kind_q;
  logic [SIZE_W-1:0] fsize_q;

  byte_word_t byte_reports[$];
  byte_word_t want;

  function automatic logic [4:0] kind_of(input logic [31:0] id);
    logic [4:0] k;
    k = KIND_UNKNOWN;
    case (id[31:24])
      CHAR_T:  k = (id[23:0] == TAIL_XXX) ? KIND_TXXX : KIND_TEXT;
      CHAR_W:  k = (id[23:0] == TAIL_XXX) ? KIND_WXXX : KIND_URL;
      default: begin
        if (id == ID_PRIV) k = KIND_PRIV;
        for (int i = 0; i < NUM_NAMED; i++) begin
          if (id == NAMED_IDS[i]) k = KIND_NAMED0 + 5'(i);
        end
      end
    endcase
    return k;
  endfunction

  function automatic byte_word_t parse_byte(input logic [7:0] b);
    byte_word_t w;
    logic       in_body;
    w = '0;
    w.data = b;
    w.role = ROLE_PAST;
    in_body = 1'b0;
    case (phase_q)
      P_TAGHDR: begin
        w.role = ROLE_TAGHDR;
        if (hdr_cnt == 4'd3) version_q = b;
        if (hdr_cnt == 4'd5) flags_q = b[7:4];
        // synchsafe: keep the low 7 bits of each size byte
        if (hdr_cnt == 4'd6) size_acc = {21'd0, b[6:0]};
        else if (hdr_cnt > 4'd6) size_acc = {size_acc[20:0], b[6:0]};
        if (hdr_cnt >= 4'd9) begin
          tag_size_q = size_acc;
          body_left = size_acc;
          hdr_cnt = '0;
          all_zero = 1'b1;
          if (body_left == '0) begin
            w.tend = 1'b1;
            phase_q = P_PAST;
          end else begin
            phase_q = flags_q[2] ? P_EXTHDR : P_FRAMEHDR;
          end
        end else begin
          hdr_cnt++;
        end
      end
      P_EXTHDR: begin
        w.role = ROLE_EXTHDR;
        in_body = 1'b1;
        if (hdr_cnt >= 4'd5) begin
          hdr_cnt = '0;
          phase_q = P_FRAMEHDR;
        end else begin
          hdr_cnt++;
        end
      end
      P_FRAMEHDR: begin
        in_body = 1'b1;
        w.role = (all_zero && b == 8'h00) ? ROLE_PADDING : ROLE_FRAMEHDR;
        if (b != 8'h00) all_zero = 1'b0;
        if (hdr_cnt < 4'd4) ident = {ident[23:0], b};
        if (hdr_cnt == 4'd4) size_acc = {21'd0, b[6:0]};
        else if (hdr_cnt > 4'd4 && hdr_cnt < 4'd8) size_acc = {size_acc[20:0], b[6:0]};
        if (hdr_cnt >= 4'd9) begin
          kind_q = all_zero ? KIND_ZERO : kind_of(ident);
          fsize_q = all_zero ? '0 : size_acc;
          w.hdone = 1'b1;
          w.kind = kind_q;
          w.fsize = fsize_q;
          hdr_cnt = '0;
          all_zero = 1'b1;
          // an empty frame goes straight on to the next header
          if (fsize_q != '0) begin
            left = fsize_q;
            phase_q = P_PAYLOAD;
          end
        end else begin
          hdr_cnt++;
        end
      end
      P_PAYLOAD: begin
        in_body = 1'b1;
        w.role = ROLE_PAYLOAD;
        w.kind = kind_q;
        w.fsize = fsize_q;
        w.offset = fsize_q - left;
        if (left != '0) left--;
        if (left == '0) begin
          w.flast = 1'b1;
          phase_q = P_FRAMEHDR;
        end
      end
      default: ;
    endcase
    // the body size cuts off whatever is in progress
    if (in_body) begin
      if (body_left != '0) body_left--;
      if (body_left == '0) begin
        w.tend = 1'b1;
        phase_q = P_PAST;
      end
    end
    w.tsize = tag_size_q;
    w.flags = flags_q;
    w.version = version_q;
    return w;
  endfunction

  task automatic flag_mismatch(input string what, input logic [SIZE_W-1:0] got,
                               input logic [SIZE_W-1:0] exp_val);
    if (fail_count_o < 40) begin
      $display("[%0t] word %0d: %s is 0x%0h, want 0x%0h", $time, checked_o, what, got, exp_val);
    end
    fail_count_o++;
  endtask

  task automatic compare_field(input string what, input logic [SIZE_W-1:0] got,
                               input logic [SIZE_W-1:0] exp_val);
    if (got !== exp_val) flag_mismatch(what, got, exp_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q = P_TAGHDR;
      hdr_cnt = '0;
      ident = '0;
      size_acc = '0;
      all_zero = 1'b1;
      left = '0;
      body_left = '0;
      tag_size_q = '0;
      flags_q = '0;
      version_q = '0;
      kind_q = '0;
      fsize_q = '0;
      byte_reports.delete();
      fail_count_o = 0;
      checked_o = 0;
      headers_o = 0;
      kinds_o = '0;
      pending_o <= 0;
    end else begin
      if (push_i && !full_i) byte_reports.push_back(parse_byte(data_byte_i));
      if (pop_i && !empty_i) begin
        if (byte_reports.size() == 0) begin
          flag_mismatch("word with nothing expected, data", SIZE_W'(data_out_i), '0);
        end else begin
          want = byte_reports.pop_front();
          compare_field("data_out", SIZE_W'(data_out_i), SIZE_W'(want.data));
          compare_field("byte_role", SIZE_W'(byte_role_i), SIZE_W'(want.role));
          compare_field("frame_kind", SIZE_W'(frame_kind_i), SIZE_W'(want.kind));
          compare_field("payload_offset", payload_offset_i, want.offset);
          compare_field("frame_size", frame_size_i, want.fsize);
          compare_field("tag_size", tag_size_i, want.tsize);
          compare_field("tag_flags", SIZE_W'(tag_flags_i), SIZE_W'(want.flags));
          compare_field("tag_version", SIZE_W'(tag_version_i), SIZE_W'(want.version));
          compare_field("header_done", SIZE_W'(header_done_i), SIZE_W'(want.hdone));
          compare_field("frame_last", SIZE_W'(frame_last_i), SIZE_W'(want.flast));
          compare_field("tag_end", SIZE_W'(tag_end_i), SIZE_W'(want.tend));
          checked_o++;
          if (want.hdone) begin
            headers_o++;
            kinds_o[want.kind] = 1'b1;
          end
        end
      end
      pending_o <= byte_reports.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the ID3v2 tag deframer testbench: clock, reset, byte stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
  import id3d_pkg::*;

  localparam int unsigned BODY_LEN   = 1360;
  localparam int unsigned IDLE_LIMIT = 2000;

  // version 0xFF, every flag bit set, body size 1360 with bit 7 set on all size bytes
  localparam logic [7:0] TAG_HDR [10] = '{
    8'h49, 8'h44, 8'h33, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h80, 8'h8A, 8'hD0
  };
  localparam logic [7:0] EXT_HDR [6] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'h06};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              push;
  logic              full;
  logic [7:0]        data_byte;
  logic              empty;
  logic              pop;
  logic [7:0]        data_out;
  logic [2:0]        byte_role;
  logic [4:0]        frame_kind;
  logic [SIZE_W-1:0] payload_offset;
  logic [SIZE_W-1:0] frame_size;
  logic [SIZE_W-1:0] tag_size;
  logic [3:0]        tag_flags;
  logic [7:0]        tag_version;
  logic              header_done;
  logic              frame_last;
  logic              tag_end;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned headers;
  logic [24:0] kinds;
  int unsigned sent;
  int unsigned popped;
  int unsigned body_used;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  id3v2_tag_deframer_top u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte),
    .empty            (empty),
    .pop              (pop),
    .data_out_o       (data_out),
    .byte_role_o      (byte_role),
    .frame_kind_o     (frame_kind),
    .payload_offset_o (payload_offset),
    .frame_size_o     (frame_size),
    .tag_size_o       (tag_size),
    .tag_flags_o      (tag_flags),
    .tag_version_o    (tag_version),
    .header_done_o    (header_done),
    .frame_last_o     (frame_last),
    .tag_end_o        (tag_end)
  );

  id3v2_deframer_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push_i           (push),
    .full_i           (full),
    .data_byte_i      (data_byte),
    .empty_i          (empty),
    .pop_i            (pop),
    .data_out_i       (data_out),
    .byte_role_i      (byte_role),
    .frame_kind_i     (frame_kind),
    .payload_offset_i (payload_offset),
    .frame_size_i     (frame_size),
    .tag_size_i       (tag_size),
    .tag_flags_i      (tag_flags),
    .tag_version_i    (tag_version),
    .header_done_i    (header_done),
    .frame_last_i     (frame_last),
    .tag_end_i        (tag_end),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .headers_o        (headers),
    .kinds_o          (kinds)
  );

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(((sent / 128) % 4) == 1);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic send_body(input logic [7:0] b);
    send_byte(b);
    body_used++;
  endtask

  // header of ID, raw size bytes and flag bytes, then payload until the body runs out
  task automatic send_frame(input logic [31:0] id, input logic [31:0] size_raw,
                            input logic [15:0] fl, input int unsigned pay_len);
    for (int i = 3; i >= 0; i--) send_body(id[8*i +: 8]);
    for (int i = 3; i >= 0; i--) send_body(size_raw[8*i +: 8]);
    send_body(fl[15:8]);
    send_body(fl[7:0]);
    for (int unsigned n = 0; n < pay_len && body_used < BODY_LEN + 3; n++) begin
      send_body(8'($urandom));
    end
  endtask

  initial begin
    logic [31:0] id;
    logic [31:0] raw;
    logic [31:0] top_bits;
    logic [15:0] fl;
    logic [27:0] sz;
    bit          drained;
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    data_byte = 8'h00;
    sent = 0;
    popped = 0;
    body_used = 0;
    drained = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (TAG_HDR[i]) send_byte(TAG_HDR[i]);
    foreach (EXT_HDR[i]) send_body(EXT_HDR[i]);
    send_frame('0, '0, '0, 0);

    while (body_used < BODY_LEN) begin
      // hold the input once until the block has drained completely
      if (!drained && body_used > BODY_LEN / 2) begin
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        drained = 1'b1;
      end
      if (BODY_LEN - body_used < 30) begin
        // largest frame size; the body end cuts it off
        send_frame("SEEK", 32'hFFFF_FFFF, 16'($urandom), 32'h0FFF_FFFF);
      end else begin
        case ($urandom_range(0, 9))
          0:       sz = '0;
          1:       sz = 28'($urandom_range(30, 90));
          default: sz = 28'($urandom_range(1, 12));
        endcase
        top_bits = $urandom;
        raw = {top_bits[3], sz[27:21], top_bits[2], sz[20:14],
               top_bits[1], sz[13:7], top_bits[0], sz[6:0]};
        fl = 16'($urandom);
        case ($urandom_range(0, 11))
          0:  id = {CHAR_T, 8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                    8'($urandom_range(48, 90))};
          1:  id = {CHAR_T, TAIL_XXX};
          2:  id = {CHAR_W, 8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                    8'($urandom_range(48, 90))};
          3:  id = {CHAR_W, TAIL_XXX};
          4,
          5:  id = NAMED_IDS[$urandom_range(0, NUM_NAMED - 1)];
          6:  id = ID_PRIV;
          7:  id = $urandom;
          8: begin
            // all-zero padding block
            id = '0;
            raw = '0;
            fl = '0;
          end
          9: begin
            // zeros up to the last flag byte: padding role breaks off there
            id = '0;
            raw = '0;
            fl = {8'h00, 8'($urandom_range(1, 255))};
          end
          10: id = {24'h0, 8'($urandom_range(1, 255))};
          default: id = {8'h00, 24'($urandom)};
        endcase
        send_frame(id, raw, fl, (id == '0 && raw == '0) ? 0 : int'(sz));
      end
    end

    // bytes past the end of the tag
    repeat (40) send_byte(8'($urandom));
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);

    $display("Sent %0d bytes: one tag with extended header and a %0d-byte body, then past-tag bytes.",
             sent, BODY_LEN);
    $display("Compared %0d words over %0d frame headers; %0d of 25 frame kinds seen.",
             checked, headers, $countones(kinds));
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // result side: random pops, two long holds to back the block up
  initial begin
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (popped == 300 || popped == 900) gap = 80;
      else gap = pick_gap(((popped / 128) % 4) == 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      popped++;
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty)) idle = 0;
      else idle++;
    end
    $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== id3v2_tag_deframer_top.f =====
rtl/id3d_pkg.sv
rtl/id3d_front.sv
rtl/id3d_queue.sv
rtl/id3d_back.sv
rtl/id3v2_tag_deframer_top.sv
rtl/id3d_checker.sv
test/id3v2_deframer_checker.sv
test/testbench.sv
